[rtl/m3inv_pkg.sv]
// ============================================================================
// m3inv_pkg
// Shared defaults and constants for the 3x3 matrix inverse pipeline.
// ============================================================================
`default_nettype none

package m3inv_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int THR_WIDTH      = 32;
    localparam int NUM_ELEM       = 9;

    localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd4295;

endpackage

`default_nettype wire

[rtl/m3inv_in_if.sv]
// ============================================================================
// m3inv_in_if
// Request channel carrying one 3x3 matrix, row-major, signed fixed point.
// ============================================================================
`default_nettype none

interface m3inv_in_if #(
    parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] a00, a01, a02;
    logic signed [ELEM_WIDTH-1:0] a10, a11, a12;
    logic signed [ELEM_WIDTH-1:0] a20, a21, a22;

    modport source (
        output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
        input  ready
    );
    modport sink (
        input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
        output ready
    );
endinterface

`default_nettype wire

[rtl/m3inv_out_if.sv]
// ============================================================================
// m3inv_out_if
// Result channel carrying the inverse matrix and its status flags.
// ============================================================================
`default_nettype none

interface m3inv_out_if #(
    parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] b00, b01, b02;
    logic signed [ELEM_WIDTH-1:0] b10, b11, b12;
    logic signed [ELEM_WIDTH-1:0] b20, b21, b22;
    logic                         singular;
    logic                         saturated;

    modport source (
        output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
        output singular, saturated,
        input  ready
    );
    modport sink (
        input  valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
        input  singular, saturated,
        output ready
    );
endinterface

`default_nettype wire

[rtl/m3inv_cfg_if.sv]
// ============================================================================
// m3inv_cfg_if
// Write channel for the singular threshold register.
// ============================================================================
`default_nettype none

interface m3inv_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [m3inv_pkg::THR_WIDTH-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/matrix3_inverse_top.sv]
// ============================================================================
// matrix3_inverse_top
// 3x3 matrix inverse by adjugate and exact determinant, pipelined divider.
// ============================================================================
// Usage:
//   i_in  : one matrix request a00..a22 (signed, FRAC_BITS fraction bits).
//   o_out : inverse b00..b22 plus singular and saturated flags.
//   i_cfg : write of singular_threshold (|det| limit in units of 2^-32);
//           always ready, write only while the pipe is empty.
// Stages : in order from request to result:
//   products, cofactors, determinant partials, terms, sum, magnitude,
//   threshold and overflow check, one stage per quotient bit, output.
// Throughput : one matrix per cycle while no result is held; the restoring divider is unrolled with
//   one register stage per quotient bit, so every stage holds its own item.
// Reset : valid bits clear, threshold returns to 4295, pipe is empty.
// Stall : a held result stops only the unbroken run of full stages behind it;
//   empty stages still fill, so requests are taken until the pipe is full.
//   Nothing is dropped or repeated.
// ============================================================================
`default_nettype none

module matrix3_inverse_top #(
    parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    m3inv_in_if.sink          i_in,
    m3inv_out_if.source       o_out,
    m3inv_cfg_if.sink         i_cfg
);

    localparam int EW       = ELEM_WIDTH;
    localparam int NE       = m3inv_pkg::NUM_ELEM;
    localparam int PW       = 2 * EW;
    localparam int CW       = PW + 1;
    localparam int HW       = EW + 1;
    localparam int DPW      = EW + HW;
    localparam int DW       = 3 * EW + 3;
    localparam int NW       = CW + 2 * FRAC_BITS;
    localparam int RW       = (NW > DW + EW) ? NW : DW + EW;
    localparam int TW       = DW + m3inv_pkg::THR_WIDTH;
    localparam int DET_FRAC = 3 * FRAC_BITS;
    localparam int DIV0     = 7;
    localparam int NS       = EW + 8;

    localparam int CP [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CQ [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CR [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CS [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    localparam int DI [3]  = '{0, 3, 6};

    localparam logic [EW-1:0] MAXPOS = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] MAXNEG = {1'b1, {(EW-1){1'b0}}};

    logic signed [EW-1:0] w_a [NE];
    logic [NS-1:0]        r_v;
    logic [NS-1:0]        adv;

    logic [m3inv_pkg::THR_WIDTH-1:0] r_threshold;

    logic [PW-1:0]        r_p1 [NE];
    logic [PW-1:0]        r_p2 [NE];
    logic signed [EW-1:0] r_ar0 [3];
    logic signed [EW-1:0] r_ar1 [3];
    logic [CW-1:0]        r_c1 [NE];
    logic [CW-1:0]        r_c2 [NE];
    logic [CW-1:0]        r_c3 [NE];
    logic [CW-1:0]        r_c4 [NE];
    logic [DPW-1:0]       r_dh [3];
    logic [DPW-1:0]       r_dl [3];
    logic [DW-1:0]        r_t [3];
    logic [DW-1:0]        r_det;
    logic [DW-1:0]        r_mag5;
    logic                 r_dneg5;
    logic [CW-1:0]        r_cmag [NE];
    logic [NE-1:0]        r_cneg;

    logic [RW-1:0]        r_rem [EW+1][NE];
    logic [EW-1:0]        r_q   [EW+1][NE];
    logic [NE-1:0]        r_neg [EW+1];
    logic [NE-1:0]        r_ovf [EW+1];
    logic [DW-1:0]        r_dmag [EW+1];
    logic [EW:0]          r_sing;

    logic [EW-1:0]        r_b [NE];
    logic                 r_sing_o;
    logic                 r_sat_o;

    assign w_a[0] = i_in.a00;
    assign w_a[1] = i_in.a01;
    assign w_a[2] = i_in.a02;
    assign w_a[3] = i_in.a10;
    assign w_a[4] = i_in.a11;
    assign w_a[5] = i_in.a12;
    assign w_a[6] = i_in.a20;
    assign w_a[7] = i_in.a21;
    assign w_a[8] = i_in.a22;

    // advance when the stage is empty or its contents move on
    always_comb begin
        adv[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int s = NS - 2; s >= 0; s--) begin
            adv[s] = !r_v[s] || adv[s+1];
        end
    end

    assign i_in.ready  = adv[0];
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_threshold <= m3inv_pkg::THR_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_threshold <= i_cfg.data;
            end
            if (adv[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (adv[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // cofactor products
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int k = 0; k < NE; k++) begin
                r_p1[k] <= w_a[CP[k]] * w_a[CQ[k]];
                r_p2[k] <= w_a[CR[k]] * w_a[CS[k]];
            end
            for (int i = 0; i < 3; i++) begin
                r_ar0[i] <= w_a[i];
            end
        end
    end

    // cofactors
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int k = 0; k < NE; k++) begin
                r_c1[k] <= {r_p1[k][PW-1], r_p1[k]} - {r_p2[k][PW-1], r_p2[k]};
            end
            r_ar1 <= r_ar0;
        end
    end

    // determinant partial products, cofactor split into high and low halves
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_dh[i] <= r_ar1[i] * $signed(r_c1[DI[i]][CW-1:EW]);
                r_dl[i] <= r_ar1[i] * $signed({1'b0, r_c1[DI[i]][EW-1:0]});
            end
            r_c2 <= r_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= ({{(DW-DPW){r_dh[i][DPW-1]}}, r_dh[i]} << EW)
                        + {{(DW-DPW){r_dl[i][DPW-1]}}, r_dl[i]};
            end
            r_c3 <= r_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_det <= r_t[0] + r_t[1] + r_t[2];
            r_c4  <= r_c3;
        end
    end

    // magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_dneg5 <= r_det[DW-1];
            r_mag5  <= r_det[DW-1] ? (~r_det + 1'b1) : r_det;
            for (int k = 0; k < NE; k++) begin
                r_cneg[k] <= r_c4[k][CW-1];
                r_cmag[k] <= r_c4[k][CW-1] ? (~r_c4[k] + 1'b1) : r_c4[k];
            end
        end
    end

    // threshold test, quotient overflow test, divider setup
    logic [TW-1:0] w_tcmp;
    logic [RW-1:0] w_num [NE];
    logic [RW-1:0] w_dtop;

    always_comb begin
        w_tcmp = {r_mag5, {m3inv_pkg::THR_WIDTH{1'b0}}} >> DET_FRAC;
        w_dtop = RW'(r_mag5) << EW;
        for (int k = 0; k < NE; k++) begin
            w_num[k] = RW'({r_cmag[k], {(2 * FRAC_BITS){1'b0}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_sing[0] <= w_tcmp <= TW'(r_threshold);
            r_dmag[0] <= r_mag5;
            for (int k = 0; k < NE; k++) begin
                r_rem[0][k] <= w_num[k];
                r_q[0][k]   <= '0;
                r_neg[0][k] <= r_cneg[k] ^ r_dneg5;
                r_ovf[0][k] <= w_num[k] >= w_dtop;
            end
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar g = 0; g < EW; g++) begin : g_div
        logic [RW-1:0] w_sh;
        logic [RW-1:0] n_rem [NE];
        logic [EW-1:0] n_q   [NE];

        always_comb begin
            w_sh = RW'(r_dmag[g]) << (EW - 1 - g);
            for (int k = 0; k < NE; k++) begin
                n_rem[k] = r_rem[g][k];
                n_q[k]   = r_q[g][k];
                if (r_rem[g][k] >= w_sh) begin
                    n_rem[k]           = r_rem[g][k] - w_sh;
                    n_q[k][EW - 1 - g] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[DIV0 + g]) begin
                r_sing[g+1] <= r_sing[g];
                r_dmag[g+1] <= r_dmag[g];
                r_neg[g+1]  <= r_neg[g];
                r_ovf[g+1]  <= r_ovf[g];
                for (int k = 0; k < NE; k++) begin
                    r_rem[g+1][k] <= n_rem[k];
                    r_q[g+1][k]   <= n_q[k];
                end
            end
        end
    end

    // sign, clamp, singular override
    logic [EW-1:0] n_b [NE];
    logic          n_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int k = 0; k < NE; k++) begin
            if (r_sing[EW]) begin
                n_b[k] = '0;
            end else if (!r_neg[EW][k]) begin
                if (r_ovf[EW][k] || r_q[EW][k] > MAXPOS) begin
                    n_b[k] = MAXPOS;
                    n_sat  = 1'b1;
                end else begin
                    n_b[k] = r_q[EW][k];
                end
            end else begin
                if (r_ovf[EW][k] || r_q[EW][k] > MAXNEG) begin
                    n_b[k] = MAXNEG;
                    n_sat  = 1'b1;
                end else begin
                    n_b[k] = ~r_q[EW][k] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            r_b      <= n_b;
            r_sing_o <= r_sing[EW];
            r_sat_o  <= n_sat;
        end
    end

    assign o_out.valid     = r_v[NS-1];
    assign o_out.b00       = r_b[0];
    assign o_out.b01       = r_b[1];
    assign o_out.b02       = r_b[2];
    assign o_out.b10       = r_b[3];
    assign o_out.b11       = r_b[4];
    assign o_out.b12       = r_b[5];
    assign o_out.b20       = r_b[6];
    assign o_out.b21       = r_b[7];
    assign o_out.b22       = r_b[8];
    assign o_out.singular  = r_sing_o;
    assign o_out.saturated = r_sat_o;

endmodule

`default_nettype wire
